### hw/rtl/foida_pkg.sv
package foida_pkg;

  // Table geometry
  localparam int unsigned POSITIONS = 128;
  localparam int unsigned ADDR_W    = $clog2(POSITIONS);
  localparam int unsigned CNT_W     = $clog2(POSITIONS + 1);

  // Field widths
  localparam int unsigned OFFSET_W  = 32;
  localparam int unsigned NUMBER_W  = 7;
  localparam int unsigned DCOUNT_W  = 8;
  localparam int unsigned MAXPAT_W  = 8;

  // Largest values the result fields can carry
  localparam logic [NUMBER_W-1:0] NUMBER_SAT = {NUMBER_W{1'b1}};
  localparam logic [DCOUNT_W-1:0] DCOUNT_SAT = {DCOUNT_W{1'b1}};

  // Reset value of the pattern limit register
  localparam logic [MAXPAT_W-1:0] MAX_PATTERNS_RST = 8'd64;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } foida_state_t;

  // One input item
  typedef struct packed {
    logic [OFFSET_W-1:0] track_offset;
    logic                first_item;
    logic                last_item;
  } foida_in_t;

  // One result item
  typedef struct packed {
    logic [NUMBER_W-1:0] pattern_number;
    logic                is_new;
    logic [DCOUNT_W-1:0] distinct_count;
    logic                over_limit;
    logic                is_last;
  } foida_res_t;

endpackage

### hw/rtl/foida_ram.sv
module foida_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/foida_search.sv
module foida_search (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  foida_pkg::foida_in_t             item,
  input  logic [foida_pkg::MAXPAT_W-1:0]   max_patterns,
  output logic                             idle,
  output logic                             res_valid,
  input  logic                             res_ready,
  output foida_pkg::foida_res_t            res
);

  foida_pkg::foida_state_t state_r, state_nxt;

  logic [foida_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [foida_pkg::CNT_W-1:0]    iss_r, iss_nxt;
  logic [foida_pkg::ADDR_W-1:0]   cmp_addr_r, cmp_addr_nxt;
  logic                           pend_r, pend_nxt;
  logic                           found_r, found_nxt;
  logic [foida_pkg::ADDR_W-1:0]   num_r, num_nxt;
  foida_pkg::foida_in_t           item_r;

  logic                           rd_en;
  logic [foida_pkg::OFFSET_W-1:0] rd_data;
  logic                           wr_en;

  logic                           fresh;
  logic                           room;
  logic [foida_pkg::CNT_W-1:0]    cnt_new;
  logic [foida_pkg::ADDR_W-1:0]   number;
  logic [31:0]                    num_ext;
  logic [31:0]                    cnt_ext;

  // Offset store, entry k holds the offset numbered k
  foida_ram #(
    .WIDTH(foida_pkg::OFFSET_W),
    .DEPTH(foida_pkg::POSITIONS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[foida_pkg::ADDR_W-1:0]),
    .wr_data (item_r.track_offset),
    .rd_en   (rd_en),
    .rd_addr (iss_r[foida_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (start) begin
      item_r <= item;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= foida_pkg::ST_IDLE;
      count_r <= '0;
      iss_r   <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      iss_r   <= iss_nxt;
      pend_r  <= pend_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_addr_r <= cmp_addr_nxt;
    num_r      <= num_nxt;
  end

  // Result of the finished search
  always_comb begin
    fresh   = !found_r;
    room    = count_r < foida_pkg::CNT_W'(foida_pkg::POSITIONS);
    cnt_new = (fresh && room) ? count_r + foida_pkg::CNT_W'(1) : count_r;
    if (!fresh) begin
      number = num_r;
    end else if (room) begin
      number = count_r[foida_pkg::ADDR_W-1:0];
    end else begin
      number = foida_pkg::ADDR_W'(foida_pkg::POSITIONS - 1);
    end
    num_ext = 32'(number);
    cnt_ext = 32'(cnt_new);

    res.pattern_number = (num_ext > 32'(foida_pkg::NUMBER_SAT)) ?
                         foida_pkg::NUMBER_SAT : num_ext[foida_pkg::NUMBER_W-1:0];
    res.is_new         = fresh;
    res.distinct_count = (cnt_ext > 32'(foida_pkg::DCOUNT_SAT)) ?
                         foida_pkg::DCOUNT_SAT : cnt_ext[foida_pkg::DCOUNT_W-1:0];
    res.over_limit     = (cnt_ext > 32'(max_patterns)) ||
                         (cnt_ext >= 32'(foida_pkg::POSITIONS));
    res.is_last        = item_r.last_item;
  end

  // Sequencer: issue one read per cycle, compare the read in the cycle after
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    iss_nxt      = iss_r;
    pend_nxt     = pend_r;
    found_nxt    = found_r;
    cmp_addr_nxt = cmp_addr_r;
    num_nxt      = num_r;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    idle         = 1'b0;
    res_valid    = 1'b0;

    case (state_r)
      foida_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          if (item.first_item) begin
            count_nxt = '0;
          end
          iss_nxt   = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          state_nxt = foida_pkg::ST_SEARCH;
        end
      end

      foida_pkg::ST_SEARCH: begin
        // Issue the next stored entry
        if (iss_r < count_r) begin
          rd_en        = 1'b1;
          iss_nxt      = iss_r + foida_pkg::CNT_W'(1);
          cmp_addr_nxt = iss_r[foida_pkg::ADDR_W-1:0];
          pend_nxt     = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        // Check the entry read last cycle
        if (pend_r && (rd_data == item_r.track_offset)) begin
          found_nxt = 1'b1;
          num_nxt   = cmp_addr_r;
          pend_nxt  = 1'b0;
          state_nxt = foida_pkg::ST_RESULT;
        end else if (!pend_r && (iss_r == count_r)) begin
          state_nxt = foida_pkg::ST_RESULT;
        end
      end

      foida_pkg::ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          wr_en     = fresh && room;
          count_nxt = cnt_new;
          state_nxt = foida_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = foida_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/first_occurrence_id_assigner_core.sv
// Flow: an accepted offset is compared with the stored entries in order; the scan stops at the
// first match, else after all N, N being the distinct offsets stored so far; then a result is offered.
// Throughput: one item at a time; the store is scanned one entry per cycle through its single read
// port, and each entry is compared in the cycle after its read is issued.
// An output register holds a finished result so the next item can enter meanwhile.
// Reset: synchronous, active low; count to zero, max_patterns to 64, offset store left as is.
module first_occurrence_id_assigner_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] track_offset
  input  logic        in_tuser,   // [0] first_item
  input  logic        in_tlast,   // last_item
  // Result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [6:0] pattern_number, [7] is_new,
                                  // [15:8] distinct_count, [16] over_limit, [23:17] zero
  output logic        out_tlast,  // is_last
  // Configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data // max_patterns
);

  logic [foida_pkg::MAXPAT_W-1:0] max_patterns_r;
  foida_pkg::foida_in_t           item;
  foida_pkg::foida_res_t          res;
  foida_pkg::foida_res_t          out_res_r;
  logic                           out_valid_r;
  logic                           idle;
  logic                           res_valid;
  logic                           res_ready;
  logic                           in_fire;

  // Pattern limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_patterns_r <= foida_pkg::MAX_PATTERNS_RST;
    end else if (cfg_wr_en) begin
      max_patterns_r <= cfg_wr_data;
    end
  end

  // Unpack input beat
  always_comb begin
    item.track_offset = in_tdata;
    item.first_item   = in_tuser;
    item.last_item    = in_tlast;
  end

  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;

  foida_search u_search (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_fire),
    .item         (item),
    .max_patterns (max_patterns_r),
    .idle         (idle),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.over_limit, out_res_r.distinct_count,
                       out_res_r.is_new, out_res_r.pattern_number};
  assign out_tlast  = out_res_r.is_last;

`ifndef SYNTH
  // Block is still busy in the cycle after it takes a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted twice in consecutive cycles");

  // A repeated offset must carry a number below the running count
  a_old_number_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.is_new) |->
      (8'(out_res_r.pattern_number) < out_res_r.distinct_count))
    else $error("repeated offset numbered at or above the count");

  // Count never exceeds the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(out_res_r.distinct_count) <= foida_pkg::POSITIONS))
    else $error("distinct count beyond table depth");

  // A result is offered only while no item is being accepted
  a_result_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_tready)
    else $error("result offered while accepting input");
`endif

endmodule
